>>> sv/bhs_pkg.sv
// ----------------------------------------------------------------------------
// bhs_pkg: shared types and codes of the bucketed hash set
// Operation and status codes, key width and the layout of one stored entry.
// ----------------------------------------------------------------------------
package bhs_pkg;

  localparam int KEY_W    = 31;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  // One slot of the table: occupied flag and key.
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

>>> sv/bhs_ram.sv
// ----------------------------------------------------------------------------
// bhs_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/bucketed_hash_set.sv
// ----------------------------------------------------------------------------
// bucketed_hash_set: hash set of 31-bit keys in fixed-depth buckets
// Bucket is key modulo NUM_BUCKETS. Insert (duplicates allowed), lookup and
// delete of one copy; every item gives one result.
//
//   channel | signals                       | direction
//   --------+-------------------------------+----------
//   input   | in_valid, in_ready, mode, key | in
//   result  | out_valid, out_ready, found,  | out
//           | status                        |
//
// Each item goes through accept, one reciprocal multiply, the remainder and
// bucket base, then one RAM read per slot through one compare, then the
// update.
// After reset the RAM is swept clear, every slot in turn, with
// in_ready low. A held result stalls the block in its final cycle; in_ready
// is high only while no item is in progress.
// ----------------------------------------------------------------------------
module bucketed_hash_set
  import bhs_pkg::*;
#(
  parameter int NUM_BUCKETS  = 8,
  parameter int BUCKET_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [MODE_W-1:0]   mode,
  input  logic [KEY_W-1:0]    key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                found,
  output logic [STATUS_W-1:0] status
);

  localparam int TOTAL = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int AW    = $clog2(TOTAL);
  localparam int BW    = $clog2(NUM_BUCKETS);
  localparam int SW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int EW    = $bits(entry_t);
  localparam int SHIFT = KEY_W + BW;
  localparam int RCPW  = KEY_W + 2;
  localparam int PW    = KEY_W + RCPW;

  localparam logic [BW:0]     NB_EXT    = (BW + 1)'(NUM_BUCKETS);
  localparam logic [BW-1:0]   NB_LO     = BW'(NUM_BUCKETS);
  localparam logic [AW-1:0]   DEPTH_A   = AW'(BUCKET_DEPTH);
  localparam logic [SW:0]     DEPTH_C   = (SW + 1)'(BUCKET_DEPTH);
  localparam logic [SW-1:0]   LAST_SLOT = SW'(BUCKET_DEPTH - 1);
  localparam logic [AW-1:0]   LAST_ADDR = AW'(TOTAL - 1);
  // ceil(2^SHIFT / NUM_BUCKETS): exact quotient for every 31-bit key
  localparam logic [RCPW-1:0] RECIP     =
    RCPW'(((64'd1 << SHIFT) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_BASE = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_ACT  = 3'd5;

  logic [2:0]        state;
  logic [AW-1:0]     clr_addr;
  logic [MODE_W-1:0] mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [PW-1:0]     prod;
  logic [AW-1:0]     base;
  logic [SW:0]       cnt;
  logic              pend;
  logic [SW-1:0]     pslot;
  logic              match_hit;
  logic [SW-1:0]     match_slot;
  logic              free_hit;
  logic [SW-1:0]     free_slot;

  logic [BW-1:0]     quot_lo;
  logic [BW-1:0]     rem;
  logic              issue;
  logic              out_free;
  logic              is_ins;
  logic              is_del;
  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wentry;
  logic [AW-1:0]     raddr;
  logic [EW-1:0]     rdata;
  entry_t            rentry;

  // Remainder: only the low bits of key - quotient * NUM_BUCKETS are needed.
  assign quot_lo   = prod[SHIFT +: BW];
  assign rem       = key_r[BW-1:0] - BW'(quot_lo * NB_LO);
  assign issue     = (state == ST_SCAN) && (cnt < DEPTH_C);
  assign raddr     = base + AW'(cnt[SW-1:0]);
  assign rentry    = entry_t'(rdata);
  assign out_free  = !out_valid || out_ready;
  assign is_ins    = (mode_r == MODE_INSERT);
  assign is_del    = (mode_r == MODE_DELETE);
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    we         = 1'b0;
    waddr      = clr_addr;
    wentry.vld = 1'b0;
    wentry.key = key_r;
    if (state == ST_CLR) begin
      we = 1'b1;
    end else if (state == ST_ACT && out_free) begin
      if (is_ins && free_hit) begin
        we         = 1'b1;
        waddr      = base + AW'(free_slot);
        wentry.vld = 1'b1;
      end else if (is_del && match_hit) begin
        we    = 1'b1;
        waddr = base + AW'(match_slot);
      end
    end
  end

  bhs_ram #(
    .WIDTH(EW),
    .DEPTH(TOTAL)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wentry),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_ACT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            mode_r <= mode;
            key_r  <= key;
            state  <= ST_MOD;
          end
        end
        ST_MOD: begin
          // 31 by 33 bit reciprocal multiply
          prod  <= PW'(key_r) * PW'(RECIP);
          state <= ST_BASE;
        end
        ST_BASE: begin
          base      <= AW'(rem) * DEPTH_A;
          cnt       <= '0;
          pend      <= 1'b0;
          match_hit <= 1'b0;
          free_hit  <= 1'b0;
          state     <= ST_SCAN;
        end
        ST_SCAN: begin
          pend  <= issue;
          pslot <= cnt[SW-1:0];
          if (issue) begin
            cnt <= cnt + (SW + 1)'(1);
          end
          // Compare the slot read in the previous cycle.
          if (pend) begin
            if (rentry.vld) begin
              if (!match_hit && rentry.key == key_r) begin
                match_hit  <= 1'b1;
                match_slot <= pslot;
              end
            end else if (!free_hit) begin
              free_hit  <= 1'b1;
              free_slot <= pslot;
            end
            if (pslot == LAST_SLOT) begin
              state <= ST_ACT;
            end
          end
        end
        ST_ACT: begin
          // Hold until the result register is free.
          if (out_free) begin
            out_valid <= 1'b1;
            found     <= match_hit;
            if (is_ins && !free_hit) begin
              status <= STATUS_FULL;
            end else if (is_del && !match_hit) begin
              status <= STATUS_NOT_FOUND;
            end else begin
              status <= STATUS_DONE;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_result_from_act: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_ACT)
    else $error("result raised outside the final step");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_BASE |-> {1'b0, rem} < NB_EXT)
    else $error("bucket index out of range");

  a_not_found_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_NOT_FOUND |-> !found)
    else $error("not-found status with found set");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    we |-> state == ST_CLR || state == ST_ACT)
    else $error("table written outside clear or update");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_MOD)
    else $error("accepted item did not start the remainder unit");

endmodule
